// ===== hw/rtl/cgo_pkg.sv =====
package cgo_pkg;

	localparam int DW = 32;
	localparam int FRAC = 16;

	// |p1 - center| always fits in DW bits
	localparam int MAG_W = DW;
	localparam int PROD_W = 2 * MAG_W;
	localparam int D2_W = PROD_W + 1;
	localparam int ROOT_W = (D2_W + 1) / 2;
	localparam int DEN_W = D2_W + ROOT_W;
	localparam int NUM_W = PROD_W + 2 * FRAC;

	// quotient bits kept; the force is clamped to the top bit of this range
	localparam int Q_W = DW + 2;
	localparam int REM_W = DEN_W + Q_W;
	localparam int DIV_STAGES = Q_W + 1;
	localparam logic [Q_W-1:0] FORCE_CAP = {1'b1, {(Q_W-1){1'b0}}};

	// slices of d2 for the denominator partial products
	localparam int PART_W = (D2_W + 2) / 3;
	localparam int PART_HI_W = D2_W - 2 * PART_W;

	localparam int SUM_W = DW + 4;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_CENTER_X = 2'd0;
	localparam reg_idx_t REG_CENTER_Y = 2'd1;
	localparam reg_idx_t REG_STRENGTH = 2'd2;

	typedef struct packed {
		logic signed [DW-1:0] pos_x;
		logic signed [DW-1:0] pos_y;
		logic signed [DW-1:0] vel_x;
		logic signed [DW-1:0] vel_y;
	} body_t;

	typedef struct packed {
		logic signed [DW-1:0] new_pos_x;
		logic signed [DW-1:0] new_pos_y;
		logic signed [DW-1:0] new_vel_x;
		logic signed [DW-1:0] new_vel_y;
		logic                 too_close;
	} result_t;

	typedef struct packed {
		logic signed [DW-1:0] p1x;
		logic signed [DW-1:0] p1y;
		logic signed [DW-1:0] vx;
		logic signed [DW-1:0] vy;
		logic [PROD_W-1:0]    numx;
		logic [PROD_W-1:0]    numy;
		logic                 negx;
		logic                 negy;
		logic                 zx;
		logic                 zy;
		logic                 close;
	} side_t;

	function automatic logic signed [DW-1:0] sat(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
		lo = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
		if (x > hi) begin
			return hi[DW-1:0];
		end else if (x < lo) begin
			return lo[DW-1:0];
		end
		return x[DW-1:0];
	endfunction

endpackage

// ===== hw/rtl/cgo_front.sv =====
module cgo_front import cgo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  body_t                in_body,
	input  logic signed [DW-1:0] center_x,
	input  logic signed [DW-1:0] center_y,
	input  logic [DW-1:0]        strength,
	output logic                 out_valid,
	output side_t                out_side,
	output logic [D2_W-1:0]      out_d2
);

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [DW-1:0] p1x_s1, p1y_s1, vx_s1, vy_s1;
	logic signed [DW-1:0] p1x_s2, p1y_s2, vx_s2, vy_s2;
	logic [MAG_W-1:0]     magx_s2, magy_s2;
	logic                 negx_s2, negy_s2, zx_s2, zy_s2;
	side_t                side_s3, side_s4;
	logic [PROD_W-1:0]    sqx_s3, sqy_s3;
	logic [D2_W-1:0]      d2_s4;

	logic signed [DW:0]   dx, dy;
	logic [PROD_W-1:0]    sqx, sqy, numx, numy;

	assign dx = (DW+1)'(p1x_s1) - (DW+1)'(center_x);
	assign dy = (DW+1)'(p1y_s1) - (DW+1)'(center_y);

	assign sqx  = magx_s2 * magx_s2;
	assign sqy  = magy_s2 * magy_s2;
	assign numx = strength * magx_s2;
	assign numy = strength * magy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// first move
			p1x_s1 <= sat(SUM_W'(in_body.pos_x) + SUM_W'(in_body.vel_x));
			p1y_s1 <= sat(SUM_W'(in_body.pos_y) + SUM_W'(in_body.vel_y));
			vx_s1  <= in_body.vel_x;
			vy_s1  <= in_body.vel_y;

			// offset from the center
			p1x_s2  <= p1x_s1;
			p1y_s2  <= p1y_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			magx_s2 <= dx[DW] ? MAG_W'(-dx) : MAG_W'(dx);
			magy_s2 <= dy[DW] ? MAG_W'(-dy) : MAG_W'(dy);
			negx_s2 <= dx[DW];
			negy_s2 <= dy[DW];
			zx_s2   <= (dx == '0);
			zy_s2   <= (dy == '0);

			// squares and force numerators
			sqx_s3        <= sqx;
			sqy_s3        <= sqy;
			side_s3.p1x   <= p1x_s2;
			side_s3.p1y   <= p1y_s2;
			side_s3.vx    <= vx_s2;
			side_s3.vy    <= vy_s2;
			side_s3.numx  <= numx;
			side_s3.numy  <= numy;
			side_s3.negx  <= negx_s2;
			side_s3.negy  <= negy_s2;
			side_s3.zx    <= zx_s2;
			side_s3.zy    <= zy_s2;
			side_s3.close <= zx_s2 & zy_s2;

			side_s4 <= side_s3;
			d2_s4   <= D2_W'(sqx_s3) + D2_W'(sqy_s3);
		end
	end

	assign out_valid = valid_s4;
	assign out_side  = side_s4;
	assign out_d2    = d2_s4;

endmodule

// ===== hw/rtl/cgo_sqrt.sv =====
module cgo_sqrt import cgo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  side_t             in_side,
	input  logic [D2_W-1:0]   in_d2,
	output logic              out_valid,
	output side_t             out_side,
	output logic [D2_W-1:0]   out_d2,
	output logic [ROOT_W-1:0] out_root
);

	localparam int RW = ROOT_W + 3;

	logic              valid_s [ROOT_W];
	side_t             side_s  [ROOT_W];
	logic [D2_W-1:0]   d2_s    [ROOT_W];
	logic [ROOT_W-1:0] root_s  [ROOT_W];
	logic [RW-1:0]     rem_s   [ROOT_W];

	// one result bit per stage, two radicand bits taken from the top down
	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vin;
		side_t             sin;
		logic [D2_W-1:0]   din;
		logic [ROOT_W-1:0] qin;
		logic [RW-1:0]     rin;
		logic [RW-1:0]     rsh;
		logic [RW-1:0]     trial;
		logic [2*ROOT_W-1:0] dpad;

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign sin = in_side;
			assign din = in_d2;
			assign qin = '0;
			assign rin = '0;
		end else begin : g_next
			assign vin = valid_s[k-1];
			assign sin = side_s[k-1];
			assign din = d2_s[k-1];
			assign qin = root_s[k-1];
			assign rin = rem_s[k-1];
		end

		assign dpad  = (2*ROOT_W)'(din);
		assign rsh   = {rin[RW-3:0], dpad[2*(ROOT_W-1-k) +: 2]};
		assign trial = RW'({qin, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= sin;
				d2_s[k]   <= din;
				if (rsh >= trial) begin
					rem_s[k]  <= rsh - trial;
					root_s[k] <= {qin[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rsh;
					root_s[k] <= {qin[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = valid_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];
	assign out_d2    = d2_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];

endmodule

// ===== hw/rtl/cgo_div.sv =====
module cgo_div import cgo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  side_t            in_side,
	input  logic [DEN_W-1:0] in_den,
	output logic             out_valid,
	output side_t            out_side,
	output logic [Q_W-1:0]   out_qx,
	output logic [Q_W-1:0]   out_qy
);

	logic             valid_s [DIV_STAGES];
	side_t            side_s  [DIV_STAGES];
	logic [DEN_W-1:0] den_s   [DIV_STAGES];
	logic [NUM_W-1:0] rem_s   [DIV_STAGES][2];
	logic [Q_W-1:0]   q_s     [DIV_STAGES][2];
	logic             ovf_s   [DIV_STAGES][2];

	logic [NUM_W-1:0] num [2];
	logic [REM_W-1:0] den_top;
	logic [Q_W-1:0]   q_out [2];

	assign num[0]  = {in_side.numx, {(2*FRAC){1'b0}}};
	assign num[1]  = {in_side.numy, {(2*FRAC){1'b0}}};
	assign den_top = {in_den, {Q_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	// flag quotients that overflow the kept bits
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			den_s[0]  <= in_den;
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= num[l];
				q_s[0][l]   <= '0;
				ovf_s[0][l] <= (REM_W'(num[l]) >= den_top);
			end
		end
	end

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
		logic [REM_W-1:0] dsh;

		assign dsh = REM_W'(den_s[k-1]) << (Q_W - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				den_s[k]  <= den_s[k-1];
				for (int l = 0; l < 2; l++) begin
					ovf_s[k][l] <= ovf_s[k-1][l];
					if (REM_W'(rem_s[k-1][l]) >= dsh) begin
						rem_s[k][l] <= NUM_W'(REM_W'(rem_s[k-1][l]) - dsh);
						q_s[k][l]   <= q_s[k-1][l] | (Q_W'(1) << (Q_W - k));
					end else begin
						rem_s[k][l] <= rem_s[k-1][l];
						q_s[k][l]   <= q_s[k-1][l];
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (ovf_s[DIV_STAGES-1][l] || (q_s[DIV_STAGES-1][l] > FORCE_CAP)) begin
				q_out[l] = FORCE_CAP;
			end else begin
				q_out[l] = q_s[DIV_STAGES-1][l];
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];
	assign out_qx    = q_out[0];
	assign out_qy    = q_out[1];

endmodule

// ===== hw/rtl/central_gravity_orbit_step.sv =====
// channel  | dir | handshake              | payload
// body     | in  | body_valid/body_stall  | body_t: pos_x, pos_y, vel_x, vel_y
// result   | out | result_valid/result_stall | result_t: new_pos_x .. too_close
// cfg      | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One body per cycle enters while body_stall is low; its result passes through 4
// front stages, 33 square root stages, 2 denominator stages, 35 divider
// stages and 2 velocity/position stages.
// Latency is set by the bit-per-stage square root and the divider.
// Reset clears valid bits and loads the default center and strength.
// A stalled result is parked in a skid register; the pipeline freezes only
// while that register is full.
module central_gravity_orbit_step import cgo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     body_valid,
	output logic     body_stall,
	input  body_t    body,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  reg_idx_t cfg_index,
	input  logic [DW-1:0] cfg_data
);

	logic signed [DW-1:0] center_x_q, center_y_q;
	logic [DW-1:0]        strength_q;
	logic                 skid_full_q;
	result_t              skid_q;
	logic                 en;

	logic              front_valid;
	side_t             front_side;
	logic [D2_W-1:0]   front_d2;
	logic              sq_valid;
	side_t             sq_side;
	logic [D2_W-1:0]   sq_d2;
	logic [ROOT_W-1:0] sq_root;

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	side_t                     side_s1, side_s2;
	logic [PART_W+ROOT_W-1:0]  pp0_s1, pp1_s1;
	logic [PART_HI_W+ROOT_W-1:0] pp2_s1;
	logic [DEN_W-1:0]          den_s2;

	logic             div_valid;
	side_t            div_side;
	logic [Q_W-1:0]   div_qx, div_qy;

	logic signed [DW-1:0] p1x_s3, p1y_s3, vx_s3, vy_s3;
	logic                 close_s3;
	result_t              res_s4;
	logic signed [SUM_W-1:0] qx_ext, qy_ext;

	assign en         = !skid_full_q;
	assign cfg_ready  = 1'b1;
	assign body_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= 32'sd41943040;
			center_y_q <= 32'sd23592960;
			strength_q <= 32'd786432000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_STRENGTH: strength_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cgo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (body_valid && !body_stall),
		.in_body  (body),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.strength (strength_q),
		.out_valid(front_valid),
		.out_side (front_side),
		.out_d2   (front_d2)
	);

	cgo_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_valid),
		.in_side  (front_side),
		.in_d2    (front_d2),
		.out_valid(sq_valid),
		.out_side (sq_side),
		.out_d2   (sq_d2),
		.out_root (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sq_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= div_valid;
			valid_s4 <= valid_s3;
		end
	end

	assign qx_ext = $signed({{(SUM_W-Q_W){1'b0}}, div_qx});
	assign qy_ext = $signed({{(SUM_W-Q_W){1'b0}}, div_qy});

	always_ff @(posedge clk) begin
		if (en) begin
			// d2 * dist in three partial products
			side_s1 <= sq_side;
			pp0_s1  <= sq_d2[PART_W-1:0] * sq_root;
			pp1_s1  <= sq_d2[2*PART_W-1:PART_W] * sq_root;
			pp2_s1  <= sq_d2[D2_W-1:2*PART_W] * sq_root;

			side_s2 <= side_s1;
			den_s2  <= DEN_W'(pp0_s1) + (DEN_W'(pp1_s1) << PART_W)
				+ (DEN_W'(pp2_s1) << (2 * PART_W));

			// force is toward the center: subtract on a positive offset
			p1x_s3   <= div_side.p1x;
			p1y_s3   <= div_side.p1y;
			close_s3 <= div_side.close;
			if (div_side.zx) begin
				vx_s3 <= div_side.vx;
			end else if (div_side.negx) begin
				vx_s3 <= sat(SUM_W'(div_side.vx) + qx_ext);
			end else begin
				vx_s3 <= sat(SUM_W'(div_side.vx) - qx_ext);
			end
			if (div_side.zy) begin
				vy_s3 <= div_side.vy;
			end else if (div_side.negy) begin
				vy_s3 <= sat(SUM_W'(div_side.vy) + qy_ext);
			end else begin
				vy_s3 <= sat(SUM_W'(div_side.vy) - qy_ext);
			end

			// second move
			res_s4.new_pos_x <= sat(SUM_W'(p1x_s3) + SUM_W'(vx_s3));
			res_s4.new_pos_y <= sat(SUM_W'(p1y_s3) + SUM_W'(vy_s3));
			res_s4.new_vel_x <= vx_s3;
			res_s4.new_vel_y <= vy_s3;
			res_s4.too_close <= close_s3;
		end
	end

	cgo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.in_side  (side_s2),
		.in_den   (den_s2),
		.out_valid(div_valid),
		.out_side (div_side),
		.out_qx   (div_qx),
		.out_qy   (div_qy)
	);

	// park a stalled item in the skid register; the pipeline advances as it is parked, then freezes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en && valid_s4 && result_stall) begin
			skid_full_q <= 1'b1;
		end else if (skid_full_q && !result_stall) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s4 && result_stall) begin
			skid_q <= res_s4;
		end
	end

	assign result_valid = skid_full_q | valid_s4;
	assign result       = skid_full_q ? skid_q : res_s4;

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(valid_s4 && result_stall))
		else $error("skid register filled without a stalled result");

	a_close_axes: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_side.close |-> div_side.zx && div_side.zy)
		else $error("zero distance flagged with a nonzero axis offset");

	a_div_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && div_valid |=> valid_s3)
		else $error("divider item lost at velocity stage");

endmodule
